### hw/rtl/idp_pkg.sv
// Shared types, constants and the opcode format table of the instruction format predecoder.
// No dependencies; every other RTL file of the block refers to this package by scoped names.
package idp_pkg;

  typedef enum logic [2:0] {
    FMT_RR  = 3'd0,
    FMT_SF  = 3'd1,
    FMT_RI1 = 3'd2,
    FMT_RI2 = 3'd3,
    FMT_RX1 = 3'd4,
    FMT_RX2 = 3'd5,
    FMT_RX3 = 3'd6,
    FMT_BAD = 3'd7
  } fmt_e;

  // Instruction lengths in bytes; zero flags an illegal opcode.
  localparam logic [2:0] LEN_ILLEGAL = 3'd0;
  localparam logic [2:0] LEN_SHORT   = 3'd2;
  localparam logic [2:0] LEN_MEDIUM  = 3'd4;
  localparam logic [2:0] LEN_LONG    = 3'd6;

  // RX family refinement, taken from the top two bits of the next word.
  localparam logic [1:0] RX_ABS  = 2'b00;
  localparam logic [1:0] RX_IDX2 = 2'b01;
  localparam logic [1:0] RX_POS  = 2'b10;
  localparam logic [1:0] RX_NEG  = 2'b11;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] next_word;
    logic [31:0] location;
  } req_t;

  typedef struct packed {
    logic [2:0]  length_bytes;
    logic [2:0]  format_code;
    logic        branch_on_true;
    logic        branch_on_false;
    logic        branch_backward;
    logic        link_branch;
    logic        mem_to_mem;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [3:0]  reg_third;
    logic signed [31:0] displacement;
  } rsp_t;

  typedef struct packed {
    logic mm;
    logic bl;
    logic bb;
    logic bf;
    logic bt;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    fmt_e   fmt;
  } op_entry_t;

  // Stage 1 -> stage 2: table entry plus the raw words.
  typedef struct packed {
    op_entry_t   entry;
    logic [31:0] first_word;
    logic [31:0] next_word;
    logic [31:0] location;
  } lkp_t;

  // Stage 2 -> stage 3: everything decoded, displacement still as two addends.
  typedef struct packed {
    fmt_e        fmt;
    flags_t      flags;
    logic [2:0]  len;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [3:0]  reg_third;
    logic [31:0] base;
    logic [31:0] addend;
  } dec_t;

  // Table entry encoding: format in bits 2:0, flags above.
  localparam logic [7:0] T_R  = 8'h00;
  localparam logic [7:0] T_S  = 8'h01;
  localparam logic [7:0] T_I1 = 8'h02;
  localparam logic [7:0] T_I2 = 8'h03;
  localparam logic [7:0] T_X  = 8'h04;
  localparam logic [7:0] T_N  = 8'h07;
  localparam logic [7:0] F_BT = 8'h08;
  localparam logic [7:0] F_BF = 8'h10;
  localparam logic [7:0] F_BB = 8'h20;
  localparam logic [7:0] F_BL = 8'h40;
  localparam logic [7:0] F_MM = 8'h80;

  localparam logic [7:0] OP_TABLE [256] = '{
    T_N, T_R, T_R|F_BT, T_R|F_BF, T_R, T_R, T_R, T_R,
    T_R, T_R, T_R, T_R, T_R, T_R, T_N, T_N,
    T_S, T_S, T_R, T_R, T_N, T_R, T_R, T_R,
    T_R, T_N, T_N, T_N, T_R, T_R, T_N, T_N,
    T_S|F_BT|F_BB, T_S|F_BT, T_S|F_BF|F_BB, T_S|F_BF, T_S, T_S, T_S, T_S,
    T_R, T_R, T_R, T_R, T_R, T_R, T_R, T_R,
    T_N, T_N, T_R, T_R, T_R, T_N, T_N, T_R,
    T_R, T_R, T_R, T_R, T_R, T_R, T_R, T_R,
    T_X, T_X|F_BL, T_X|F_BT, T_X|F_BF, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_N, T_N,
    T_X, T_X, T_N, T_N, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_N, T_N, T_X, T_N, T_X, T_N, T_N, T_X,
    T_S, T_N, T_N, T_N, T_X|F_MM, T_N, T_N, T_N,
    T_S, T_S, T_R, T_R, T_R, T_R, T_R, T_R,
    T_R, T_R, T_R, T_R, T_N, T_R, T_R, T_N,
    T_N, T_N, T_N, T_N, T_R, T_R, T_R, T_R,
    T_N, T_N, T_N, T_N, T_N, T_N, T_N, T_N,
    T_N, T_N, T_N, T_N, T_N, T_N, T_N, T_N,
    T_N, T_N, T_N, T_N, T_N, T_N, T_N, T_N,
    T_X, T_X, T_X, T_I1, T_I1, T_I1, T_I1, T_I1,
    T_I1, T_I1, T_I1, T_I1, T_I1, T_I1, T_I1, T_I1,
    T_X, T_X, T_X, T_X, T_X, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_N, T_X, T_X, T_X,
    T_X, T_X, T_X, T_X, T_N, T_X, T_X, T_X,
    T_R, T_I1, T_I1, T_I1, T_I1, T_I1, T_I1, T_I1,
    T_N, T_N, T_N, T_I2, T_I2, T_I2, T_I2, T_I2,
    T_I2, T_I2, T_I2, T_I2, T_N, T_N, T_N, T_N
  };

endpackage

### hw/rtl/idp_lookup.sv
// Stage 1 of the predecoder: opcode table lookup and capture of the request words.
// Depends on idp_pkg.
module idp_lookup (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  idp_pkg::req_t  req_i,
  output logic           valid_o,
  output idp_pkg::lkp_t  lkp_o
);

  logic          valid_q;
  idp_pkg::lkp_t lkp_d, lkp_q;

  always_comb begin
    lkp_d.entry      = idp_pkg::op_entry_t'(idp_pkg::OP_TABLE[req_i.first_word[31:24]]);
    lkp_d.first_word = req_i.first_word;
    lkp_d.next_word  = req_i.next_word;
    lkp_d.location   = req_i.location;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lkp_q <= lkp_d;
    end
  end

  assign valid_o = valid_q;
  assign lkp_o   = lkp_q;

endmodule

### hw/rtl/idp_decode.sv
// Stage 2 of the predecoder: format refinement, length, register fields and displacement operands.
// Depends on idp_pkg.
module idp_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  idp_pkg::lkp_t  lkp_i,
  output logic           valid_o,
  output idp_pkg::dec_t  dec_o
);

  logic          valid_q;
  idp_pkg::dec_t dec_d, dec_q;
  logic [31:0]   w0, w1;

  assign w0 = lkp_i.first_word;
  assign w1 = lkp_i.next_word;

  always_comb begin
    dec_d.fmt        = lkp_i.entry.fmt;
    dec_d.flags      = lkp_i.entry.flags;
    dec_d.len        = idp_pkg::LEN_ILLEGAL;
    dec_d.reg_first  = w0[23:20];
    dec_d.reg_second = w0[19:16];
    dec_d.reg_third  = 4'd0;
    dec_d.base       = 32'd0;
    dec_d.addend     = 32'd0;
    case (lkp_i.entry.fmt)
      idp_pkg::FMT_RR, idp_pkg::FMT_SF: begin
        dec_d.len = idp_pkg::LEN_SHORT;
      end
      idp_pkg::FMT_RI1: begin
        dec_d.len    = idp_pkg::LEN_MEDIUM;
        dec_d.addend = {{16{w0[15]}}, w0[15:0]};
      end
      idp_pkg::FMT_RI2: begin
        dec_d.len    = idp_pkg::LEN_LONG;
        dec_d.addend = w1;
      end
      idp_pkg::FMT_RX1: begin
        case (w1[31:30])
          idp_pkg::RX_ABS: begin
            dec_d.len    = idp_pkg::LEN_MEDIUM;
            dec_d.addend = {16'h0000, w1[31:16]};
          end
          idp_pkg::RX_POS: begin
            dec_d.fmt    = idp_pkg::FMT_RX2;
            dec_d.len    = idp_pkg::LEN_MEDIUM;
            dec_d.addend = {17'h00000, w1[30:16]};
            dec_d.base   = lkp_i.location + idp_pkg::PC_STEP;
          end
          idp_pkg::RX_NEG: begin
            dec_d.fmt    = idp_pkg::FMT_RX2;
            dec_d.len    = idp_pkg::LEN_MEDIUM;
            dec_d.addend = {16'hffff, w1[31:16]};
            dec_d.base   = lkp_i.location + idp_pkg::PC_STEP;
          end
          default: begin
            dec_d.fmt       = idp_pkg::FMT_RX3;
            dec_d.len       = idp_pkg::LEN_LONG;
            dec_d.reg_third = w1[27:24];
            dec_d.addend    = {{8{w1[23]}}, w1[23:0]};
          end
        endcase
      end
      default: begin
        // illegal opcode: drop all flags
        dec_d.flags = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

### hw/rtl/idp_disp.sv
// Stage 3 of the predecoder: final displacement add and the result register.
// Depends on idp_pkg.
module idp_disp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  idp_pkg::dec_t  dec_i,
  output logic           valid_o,
  output idp_pkg::rsp_t  rsp_o
);

  logic          valid_q;
  idp_pkg::rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d.length_bytes    = dec_i.len;
    rsp_d.format_code     = dec_i.fmt;
    rsp_d.branch_on_true  = dec_i.flags.bt;
    rsp_d.branch_on_false = dec_i.flags.bf;
    rsp_d.branch_backward = dec_i.flags.bb;
    rsp_d.link_branch     = dec_i.flags.bl;
    rsp_d.mem_to_mem      = dec_i.flags.mm;
    rsp_d.reg_first       = dec_i.reg_first;
    rsp_d.reg_second      = dec_i.reg_second;
    rsp_d.reg_third       = dec_i.reg_third;
    // wraps modulo 2^32
    rsp_d.displacement    = $signed(dec_i.base + dec_i.addend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

### hw/rtl/instruction_format_predecoder.sv
// Top level of the instruction format predecoder: three-stage pipeline.
// Depends on idp_pkg, idp_lookup, idp_decode and idp_disp.
//
// Usage:
//   Request channel: drive req_i (first word, word at address plus two, address)
//   and raise start. A request is taken at each rising edge where start is high
//   and busy is low. busy stays low: the pipeline takes one request per cycle.
//   Result channel: done_o is high for one cycle per result with rsp_o valid in that
//   cycle. Every request yields exactly one result, in request order.
//   Stages, each ending in a register: opcode table lookup, format decode
//     with the address+4 add, final displacement add. Throughput: one request
//     per cycle.
//   Reset: rst_ni clears the per-stage valid bits; requests in flight are
//   dropped, payload registers keep stale data that is never strobed out.
//   The receiver cannot stall, so the pipeline never holds; nothing waits.
//   Illegal opcodes give length 0, format 7 and no flags; register fields are
//   still taken from the first word.
module instruction_format_predecoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  idp_pkg::req_t  req_i,
  output logic           done_o,
  output idp_pkg::rsp_t  rsp_o
);

  logic          s1_valid, s2_valid;
  idp_pkg::lkp_t s1_lkp;
  idp_pkg::dec_t s2_dec;

  // The pipeline always advances, so the request side is never held off.
  assign busy = 1'b0;

  idp_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .req_i   (req_i),
    .valid_o (s1_valid),
    .lkp_o   (s1_lkp)
  );

  idp_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .lkp_i   (s1_lkp),
    .valid_o (s2_valid),
    .dec_o   (s2_dec)
  );

  idp_disp u_disp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .dec_i   (s2_dec),
    .valid_o (done_o),
    .rsp_o   (rsp_o)
  );

  // An illegal length always comes with the illegal format and no flags.
  a_illegal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.length_bytes == idp_pkg::LEN_ILLEGAL) |->
      (rsp_o.format_code == idp_pkg::FMT_BAD && !rsp_o.branch_on_true &&
       !rsp_o.branch_on_false && !rsp_o.branch_backward &&
       !rsp_o.link_branch && !rsp_o.mem_to_mem))
    else $error("illegal opcode result carries format or flags");

  // The third register field is only used by RX3.
  a_reg_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.format_code != idp_pkg::FMT_RX3) |-> (rsp_o.reg_third == 4'd0))
    else $error("reg_third set outside RX3");

  // RX3 is a long instruction.
  a_rx3_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.format_code == idp_pkg::FMT_RX3) |->
      (rsp_o.length_bytes == idp_pkg::LEN_LONG))
    else $error("RX3 result with wrong length");

  // Formats without a displacement field give zero.
  a_no_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.format_code == idp_pkg::FMT_RR ||
                rsp_o.format_code == idp_pkg::FMT_SF ||
                rsp_o.format_code == idp_pkg::FMT_BAD)) |->
      (rsp_o.displacement == 32'sd0))
    else $error("displacement nonzero for a format without one");

endmodule

### dv/instruction_format_predecoder_tb.sv
// Self-checking testbench for the instruction format predecoder: drives requests, predicts
// each decode independently and compares every strobed result in order. Depends on idp_pkg.
module instruction_format_predecoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import idp_pkg::*;

  // Clock, reset and block ports. Every input starts at a known value.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  // Decodes still owed by the block, oldest first.
  rsp_t        pending_decodes[$];
  int unsigned mismatch_count = 0;
  // Hold start high between requests while set, to get stretches without idle cycles.
  bit          back_to_back   = 1'b0;

  instruction_format_predecoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------------

  function automatic bit op_in(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
    return (op >= lo) && (op <= hi);
  endfunction

  // Base format of an opcode. The RX family comes back as RX1 and is refined later
  // from the top bits of the next word.
  function automatic fmt_e base_format(logic [7:0] op);
    fmt_e fmt;
    fmt = FMT_BAD;
    if (op_in(op, 8'h40, 8'h4D) || op_in(op, 8'h50, 8'h51) || op_in(op, 8'h54, 8'h7F) ||
        op == 8'h82 || op == 8'h84 || op == 8'h87 || op == 8'h8C ||
        op_in(op, 8'hC0, 8'hC2) || op_in(op, 8'hD0, 8'hDB) || op_in(op, 8'hDD, 8'hE3) ||
        op_in(op, 8'hE5, 8'hE7)) begin
      fmt = FMT_RX1;
    end else if (op_in(op, 8'hC3, 8'hCF) || op_in(op, 8'hE9, 8'hEF)) begin
      fmt = FMT_RI1;
    end else if (op_in(op, 8'hF3, 8'hFB)) begin
      fmt = FMT_RI2;
    end else if (op_in(op, 8'h10, 8'h11) || op_in(op, 8'h20, 8'h27) || op == 8'h88 ||
                 op_in(op, 8'h90, 8'h91)) begin
      fmt = FMT_SF;
    end else if (op_in(op, 8'h01, 8'h0D) || op_in(op, 8'h12, 8'h13) ||
                 op_in(op, 8'h15, 8'h18) || op_in(op, 8'h1C, 8'h1D) ||
                 op_in(op, 8'h28, 8'h2F) || op_in(op, 8'h32, 8'h34) ||
                 op_in(op, 8'h37, 8'h3F) || op_in(op, 8'h92, 8'h9B) ||
                 op_in(op, 8'h9D, 8'h9E) || op_in(op, 8'hA4, 8'hA7) || op == 8'hE8) begin
      fmt = FMT_RR;
    end
    return fmt;
  endfunction

  // Branch, link and storage-to-storage flags; only a handful of opcodes carry any.
  function automatic flags_t opcode_flags(logic [7:0] op);
    flags_t f;
    f = '0;
    case (op)
      8'h02, 8'h21, 8'h42: f.bt = 1'b1;
      8'h03, 8'h23, 8'h43: f.bf = 1'b1;
      8'h20: begin
        f.bt = 1'b1;
        f.bb = 1'b1;
      end
      8'h22: begin
        f.bf = 1'b1;
        f.bb = 1'b1;
      end
      8'h41: f.bl = 1'b1;
      8'h8C: f.mm = 1'b1;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic rsp_t decode_instruction(req_t r);
    rsp_t        d;
    fmt_e        fmt;
    flags_t      f;
    logic [31:0] w0;
    logic [31:0] w1;
    d   = '0;
    w0  = r.first_word;
    w1  = r.next_word;
    fmt = base_format(w0[31:24]);
    f   = opcode_flags(w0[31:24]);
    // Register fields come from the first word even for illegal opcodes.
    d.reg_first  = w0[23:20];
    d.reg_second = w0[19:16];
    case (fmt)
      FMT_RR, FMT_SF: d.length_bytes = LEN_SHORT;
      FMT_RI1: begin
        d.length_bytes = LEN_MEDIUM;
        d.displacement = {{16{w0[15]}}, w0[15:0]};
      end
      FMT_RI2: begin
        d.length_bytes = LEN_LONG;
        d.displacement = w1;
      end
      FMT_RX1: begin
        case (w1[31:30])
          RX_ABS: begin
            d.length_bytes = LEN_MEDIUM;
            d.displacement = {16'h0000, w1[31:16]};
          end
          RX_POS: begin
            fmt = FMT_RX2;
            d.length_bytes = LEN_MEDIUM;
            d.displacement = {17'h00000, w1[30:16]} + r.location + PC_STEP;
          end
          RX_NEG: begin
            fmt = FMT_RX2;
            d.length_bytes = LEN_MEDIUM;
            d.displacement = {16'hFFFF, w1[31:16]} + r.location + PC_STEP;
          end
          default: begin
            fmt = FMT_RX3;
            d.length_bytes = LEN_LONG;
            d.reg_third    = w1[27:24];
            d.displacement = {{8{w1[23]}}, w1[23:0]};
          end
        endcase
      end
      default: begin
        // Illegal opcode: no length, no flags, no displacement.
        d.length_bytes = LEN_ILLEGAL;
        f = '0;
      end
    endcase
    d.format_code     = fmt;
    d.branch_on_true  = f.bt;
    d.branch_on_false = f.bf;
    d.branch_backward = f.bb;
    d.link_branch     = f.bl;
    d.mem_to_mem      = f.mm;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic [31:0] fw, logic [31:0] nw, logic [31:0] loc);
    req_t r;
    r.first_word = fw;
    r.next_word  = nw;
    r.location   = loc;
    return r;
  endfunction

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (back_to_back) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Addresses biased toward both ends of the space so the PC-relative adds wrap.
  function automatic logic [31:0] pick_location();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      1:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Present one request, hold it until busy is low at a rising edge, then queue
  // its predicted decode. Start stays high on return; a following gap lowers it.
  task automatic send_request(req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_decodes.push_back(decode_instruction(r));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: one strobe per result, no back-pressure
  // ---------------------------------------------------------------------------

  task automatic flag_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t ns: mismatch on %s: expected %h, actual %h", $time, field, exp_v, act_v);
    mismatch_count++;
  endtask

  rsp_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual %h", $time, rsp_o);
        mismatch_count++;
      end else begin
        oldest = pending_decodes.pop_front();
        if (rsp_o.length_bytes !== oldest.length_bytes)
          flag_field("length_bytes", 32'(oldest.length_bytes), 32'(rsp_o.length_bytes));
        if (rsp_o.format_code !== oldest.format_code)
          flag_field("format_code", 32'(oldest.format_code), 32'(rsp_o.format_code));
        if (rsp_o.branch_on_true !== oldest.branch_on_true)
          flag_field("branch_on_true", 32'(oldest.branch_on_true),
                     32'(rsp_o.branch_on_true));
        if (rsp_o.branch_on_false !== oldest.branch_on_false)
          flag_field("branch_on_false", 32'(oldest.branch_on_false),
                     32'(rsp_o.branch_on_false));
        if (rsp_o.branch_backward !== oldest.branch_backward)
          flag_field("branch_backward", 32'(oldest.branch_backward),
                     32'(rsp_o.branch_backward));
        if (rsp_o.link_branch !== oldest.link_branch)
          flag_field("link_branch", 32'(oldest.link_branch), 32'(rsp_o.link_branch));
        if (rsp_o.mem_to_mem !== oldest.mem_to_mem)
          flag_field("mem_to_mem", 32'(oldest.mem_to_mem), 32'(rsp_o.mem_to_mem));
        if (rsp_o.reg_first !== oldest.reg_first)
          flag_field("reg_first", 32'(oldest.reg_first), 32'(rsp_o.reg_first));
        if (rsp_o.reg_second !== oldest.reg_second)
          flag_field("reg_second", 32'(oldest.reg_second), 32'(rsp_o.reg_second));
        if (rsp_o.reg_third !== oldest.reg_third)
          flag_field("reg_third", 32'(oldest.reg_third), 32'(rsp_o.reg_third));
        if (rsp_o.displacement !== oldest.displacement)
          flag_field("displacement", oldest.displacement, rsp_o.displacement);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every format, every flagged opcode and each corner of the
  // displacement rules.
  task automatic test_directed();
    // Illegal opcodes at both ends of the opcode range; register fields still decode.
    send_request(make_req(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(32'hDC5A_1234, 32'h5A5A_5A5A, 32'h0000_1000));
    // Register-register, plain and with the branch flags.
    send_request(make_req(32'h01AB_FFFF, 32'hFFFF_FFFF, 32'h1234_5678));
    send_request(make_req(32'h0200_0000, 32'h4000_0000, 32'h0000_0000));
    send_request(make_req(32'h03F0_0000, 32'h8000_0000, 32'h0000_0000));
    send_request(make_req(32'hE80F_0000, 32'hC000_0000, 32'h0000_0000));
    // Short format: backward and forward branches of both senses, then a plain one.
    send_request(make_req(32'h2010_0000, 32'h0, 32'h0000_0100));
    send_request(make_req(32'h2120_0000, 32'h0, 32'h0000_0100));
    send_request(make_req(32'h2230_0000, 32'h0, 32'h0000_0100));
    send_request(make_req(32'h2340_0000, 32'h0, 32'h0000_0100));
    send_request(make_req(32'h88FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Immediate forms: sign boundaries of the 16-bit immediate and the full word.
    send_request(make_req(32'hC312_8000, 32'hFFFF_FFFF, 32'h0));
    send_request(make_req(32'hEF34_7FFF, 32'h0, 32'h0));
    send_request(make_req(32'hF356_0000, 32'h8000_0000, 32'h0));
    send_request(make_req(32'hFB78_FFFF, 32'h7FFF_FFFF, 32'h0));
    // Indexed forms: absolute, link and branch flags.
    send_request(make_req(32'h4112_0000, 32'h3FFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(32'h4200_0000, 32'h0000_0000, 32'h0));
    send_request(make_req(32'h4300_0000, 32'h1234_0000, 32'h0));
    // Relative forms: positive and negative offsets with the address add wrapping.
    send_request(make_req(32'h5800_0000, 32'h8000_0000, 32'hFFFF_FFFC));
    send_request(make_req(32'h5800_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(32'h5800_0000, 32'hC000_0000, 32'h0000_0000));
    // Second index: negative and positive 24-bit displacement, register field extremes.
    send_request(make_req(32'h6000_0000, 32'h4F80_0000, 32'h0));
    send_request(make_req(32'h6000_0000, 32'h707F_FFFF, 32'h0));
    // Storage-to-storage: only the first operand part is decoded.
    send_request(make_req(32'h8C9A_0000, 32'hA123_4567, 32'h0000_2000));
  endtask

  // Every opcode once with random words; the first part runs without idle cycles.
  task automatic test_opcode_sweep();
    for (int op = 0; op < 256; op++) begin
      back_to_back = (op < 64);
      send_request(make_req({op[7:0], 24'($urandom())}, $urandom(), $urandom()));
    end
    back_to_back = 1'b0;
  endtask

  // RX family only, spreading the refinement bits and the address across its range.
  task automatic test_rx_addressing();
    logic [7:0]  op;
    logic [31:0] nw;
    for (int n = 0; n < 120; n++) begin
      do op = 8'($urandom()); while (base_format(op) != FMT_RX1);
      nw = $urandom();
      // Push the offset field to its extremes now and then.
      case ($urandom_range(0, 5))
        0:       nw[29:16] = '0;
        1:       nw[29:16] = '1;
        default: nw = nw;
      endcase
      back_to_back = ((n / 30) % 2 == 1);
      send_request(make_req({op, 24'($urandom())}, nw, pick_location()));
    end
    back_to_back = 1'b0;
  endtask

  // Uniform opcodes and words, with bursts switched on and off in blocks.
  task automatic test_random_mix();
    for (int n = 0; n < 200; n++) begin
      if (n % 40 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      send_request(make_req($urandom(), $urandom(), pick_location()));
    end
    back_to_back = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned drain_cycles;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_opcode_sweep();
    test_rx_addressing();
    test_random_mix();
    start <= 1'b0;

    // Drain: wait for every owed decode, bounded, then keep the clock running in case a
    // stray strobe follows.
    drain_cycles = 0;
    while (pending_decodes.size() != 0 && drain_cycles < 64) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_decodes.size() != 0) begin
      $display("%0t ns: missing results: expected %0d more, actual 0",
               $time, pending_decodes.size());
      mismatch_count += pending_decodes.size();
    end
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("%0t ns: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
